/* rtl/rmsd_pkg.sv */
// Shared constants and types for the running mean and deviation block.
package rmsd_pkg;

  // Sample counter width
  localparam int COUNT_WIDTH = 32;

  // Shared adder width: covers the 64-bit sum plus carry, and the divider remainder
  localparam int ALU_W = (COUNT_WIDTH + 2 > 66) ? COUNT_WIDTH + 2 : 66;

  // Remainder register: divider needs COUNT_WIDTH+1 bits, square root needs 34
  localparam int REM_W = (COUNT_WIDTH + 1 > 34) ? COUNT_WIDTH + 1 : 34;

  // Step counter and the last step of each iterative phase
  localparam int ITER_W = 6;
  localparam logic [ITER_W-1:0] MEAN_DIV_LAST = ITER_W'(32);
  localparam logic [ITER_W-1:0] MUL_LAST      = ITER_W'(32);
  localparam logic [ITER_W-1:0] VAR_DIV_LAST  = ITER_W'(63);
  localparam logic [ITER_W-1:0] SQRT_LAST     = ITER_W'(31);

  typedef logic [COUNT_WIDTH-1:0] count_t;

  localparam count_t CNT_MAX = '1;
  localparam count_t CNT_ONE = count_t'(1);
  localparam count_t CNT_TWO = count_t'(2);

  // Request commands
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

endpackage

/* rtl/running_mean_stddev.sv */
// Top level: online mean and sample standard deviation over a shared adder.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------------
//  input    | in_valid / in_stall  | command, rate_error
//  output   | out_valid / out_stall| sample_count, mean_value, std_dev,
//           |                      | std_dev_valid, count_saturated
//
// One request at a time; in_stall is high while a request is in work.
// A sample runs up to 33 divider steps for the mean, 33 multiply steps for the
// deviation product, 64 divider steps for M2/(n-1) and 32 square root steps,
// all on the one shared 66-bit adder.
// A result waits in the output register under out_stall while the next request
// is accepted; rst is synchronous and zeroes the statistics.
module running_mean_stddev (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [31:0] rate_error,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] sample_count,
  output logic [31:0] mean_value,
  output logic [31:0] std_dev,
  output logic        std_dev_valid,
  output logic        count_saturated
);
  import rmsd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DELTA,
    S_NEGD,
    S_DIVM,
    S_MEAN,
    S_AFTER,
    S_MUL,
    S_M2ADD,
    S_VARS,
    S_DIVV,
    S_SQRT,
    S_FINISH
  } state_t;

  state_t              state;
  count_t              count_reg;
  logic [31:0]         mean_reg;
  logic [63:0]         sq_dev_sum;
  logic [31:0]         x_reg;
  logic                delta_neg;
  logic [32:0]         mag_a;
  logic [32:0]         mag_b;
  logic [63:0]         work;
  logic [63:0]         prod;
  logic [REM_W-1:0]    rem;
  count_t              divisor;
  logic [31:0]         root;
  logic [ITER_W-1:0]   iter;

  logic [ALU_W-1:0]    alu_a;
  logic [ALU_W-1:0]    alu_b;
  logic                alu_sub;
  logic [ALU_W:0]      alu_sum;
  logic                alu_ge;
  logic [ALU_W-1:0]    x_ext;
  logic [ALU_W-1:0]    mean_ext;
  logic [ALU_W-1:0]    div_trial;
  logic [ALU_W-1:0]    sq_trial;
  logic [63:0]         count_ext;
  logic                in_take;
  logic                out_free;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign x_ext     = {{(ALU_W-32){x_reg[31]}}, x_reg};
  assign mean_ext  = {{(ALU_W-32){mean_reg[31]}}, mean_reg};
  assign div_trial = ALU_W'({rem[COUNT_WIDTH-1:0], work[63]});
  assign sq_trial  = ALU_W'({rem[33:0], work[63:62]});
  assign count_ext = 64'(count_reg);

  // Select operands of the shared adder
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state)
      S_DELTA: begin
        alu_a   = x_ext;
        alu_b   = mean_ext;
        alu_sub = 1'b1;
      end
      S_NEGD: begin
        alu_b   = {{(ALU_W-33){mag_a[32]}}, mag_a};
        alu_sub = 1'b1;
      end
      S_DIVM, S_DIVV: begin
        alu_a   = div_trial;
        alu_b   = ALU_W'(divisor);
        alu_sub = 1'b1;
      end
      S_MEAN: begin
        alu_a   = mean_ext;
        alu_b   = ALU_W'(work[32:0]);
        alu_sub = delta_neg;
      end
      S_AFTER: begin
        alu_a   = delta_neg ? mean_ext : x_ext;
        alu_b   = delta_neg ? x_ext : mean_ext;
        alu_sub = 1'b1;
      end
      S_MUL: begin
        alu_a = ALU_W'(prod);
        alu_b = ALU_W'(work);
      end
      S_M2ADD: begin
        alu_a = ALU_W'(sq_dev_sum);
        alu_b = ALU_W'(prod);
      end
      S_SQRT: begin
        alu_a   = sq_trial;
        alu_b   = ALU_W'({root, 2'b01});
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  // Shared adder and its sign test
  assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                 + (ALU_W+1)'(alu_sub);
  assign alu_ge  = !alu_sum[ALU_W-1];

  // Sequencer, statistics and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      count_reg  <= '0;
      mean_reg   <= '0;
      sq_dev_sum <= '0;
    end else begin
      // drop the result once taken, unless a new one is loaded
      if (out_valid && !out_stall && state != S_FINISH) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            x_reg   <= rate_error;
            divisor <= count_reg + CNT_ONE;
            if (command == CMD_CLEAR) begin
              count_reg  <= '0;
              mean_reg   <= '0;
              sq_dev_sum <= '0;
              root       <= '0;
              state      <= S_FINISH;
            end else if (count_reg == CNT_MAX) begin
              state <= S_VARS;
            end else begin
              state <= S_DELTA;
            end
          end
        end

        S_DELTA: begin
          delta_neg <= alu_sum[ALU_W-1];
          mag_a     <= alu_sum[32:0];
          state     <= S_NEGD;
        end

        // take magnitude of delta and load the divider
        S_NEGD: begin
          if (delta_neg) begin
            mag_a <= alu_sum[32:0];
            work  <= {alu_sum[32:0], 31'b0};
          end else begin
            work  <= {mag_a, 31'b0};
          end
          rem   <= '0;
          iter  <= '0;
          state <= S_DIVM;
        end

        S_DIVM, S_DIVV: begin
          work <= {work[62:0], alu_ge};
          if (state == S_DIVV && iter == VAR_DIV_LAST) begin
            rem   <= '0;
            root  <= '0;
            iter  <= '0;
            state <= S_SQRT;
          end else begin
            rem  <= alu_ge ? alu_sum[REM_W-1:0] : REM_W'(div_trial);
            iter <= iter + 1'b1;
            if (state == S_DIVM && iter == MEAN_DIV_LAST) begin
              state <= S_MEAN;
            end
          end
        end

        S_MEAN: begin
          mean_reg  <= alu_sum[31:0];
          count_reg <= divisor;
          state     <= S_AFTER;
        end

        // load the multiplier with |delta| and |x - new mean|
        S_AFTER: begin
          mag_b <= alu_sum[32:0];
          work  <= 64'(mag_a);
          prod  <= '0;
          iter  <= '0;
          state <= S_MUL;
        end

        S_MUL: begin
          if (mag_b[0]) begin
            prod <= alu_sum[63:0];
          end
          mag_b <= {1'b0, mag_b[32:1]};
          work  <= {work[62:0], 1'b0};
          iter  <= iter + 1'b1;
          if (iter == MUL_LAST) begin
            state <= S_M2ADD;
          end
        end

        // saturate M2 on carry out
        S_M2ADD: begin
          sq_dev_sum <= alu_sum[64] ? '1 : alu_sum[63:0];
          state      <= S_VARS;
        end

        S_VARS: begin
          if (count_reg < CNT_TWO) begin
            root  <= '0;
            state <= S_FINISH;
          end else begin
            divisor <= count_reg - CNT_ONE;
            work    <= sq_dev_sum;
            rem     <= '0;
            iter    <= '0;
            state   <= S_DIVV;
          end
        end

        // one root bit per step
        S_SQRT: begin
          rem  <= alu_ge ? alu_sum[REM_W-1:0] : REM_W'(sq_trial);
          root <= {root[30:0], alu_ge};
          work <= {work[61:0], 2'b00};
          iter <= iter + 1'b1;
          if (iter == SQRT_LAST) begin
            state <= S_FINISH;
          end
        end

        // hold until the output register is free
        S_FINISH: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            sample_count    <= (count_ext > 64'h0000_0000_FFFF_FFFF) ?
                               32'hFFFF_FFFF : count_ext[31:0];
            mean_value      <= mean_reg;
            std_dev         <= root;
            std_dev_valid   <= (count_reg >= CNT_TWO);
            count_saturated <= (count_reg == CNT_MAX);
            state           <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
